/* hdl/nurbs_knot_vector_engine_defines.svh */
// assertion macros for the knot vector engine
`ifndef NURBS_KNOT_VECTOR_ENGINE_DEFINES_SVH
`define NURBS_KNOT_VECTOR_ENGINE_DEFINES_SVH
// implication checked on every clock outside reset
`define NKV_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("nkv check failed");
// implication whose consequent is checked in the cycle after the antecedent
`define NKV_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("nkv check failed");
`endif

/* hdl/nkv_pkg.sv */
`default_nettype none
package nkv_pkg;
  localparam int NumKnots = 64;
  localparam int IdxW = 6;
  localparam int CntW = 7;
  localparam int KnotW = 32;
  localparam int TolW = 16;
  localparam logic [IdxW-1:0] LastLimit = 6'd63;
  localparam logic [KnotW-1:0] OneQ16 = 32'h0001_0000;
  localparam logic [2:0] ActInit = 3'd0;
  localparam logic [2:0] ActWrite = 3'd1;
  localparam logic [2:0] ActSpan = 3'd2;
  localparam logic [2:0] ActInsert = 3'd3;
  localparam logic [2:0] ActMultIdx = 3'd4;
  localparam logic [2:0] ActMultVal = 3'd5;
  localparam logic CfgDegree = 1'b0;
  localparam logic CfgTolerance = 1'b1;
  typedef logic signed [KnotW-1:0] knot_t;
  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctl_t;
  typedef struct packed {
    logic near;
    logic less;
  } cell_flag_t;
endpackage
`default_nettype wire

/* hdl/nkv_cell.sv */
`default_nettype none
module nkv_cell (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire nkv_pkg::cell_ctl_t       ctl,
  input  wire nkv_pkg::knot_t           din,
  input  wire nkv_pkg::knot_t           left,
  input  wire nkv_pkg::knot_t           ref_value,
  input  wire nkv_pkg::knot_t           query,
  input  wire logic [nkv_pkg::TolW-1:0] tol,
  output nkv_pkg::knot_t                knot,
  output nkv_pkg::cell_flag_t           flag
);
  import nkv_pkg::*;
  logic signed [KnotW:0] diff;
  logic [KnotW:0] dabs;

  always_ff @(posedge clk) begin
    if (rst) begin
      knot <= '0;
    end else if (ctl.load) begin
      knot <= din;
    end else if (ctl.shift) begin
      knot <= left;
    end
  end

  always_comb begin
    diff = {knot[KnotW-1], knot} - {ref_value[KnotW-1], ref_value};
    dabs = diff[KnotW] ? (KnotW+1)'(-diff) : diff;
    flag.near = dabs <= {{(KnotW+1-TolW){1'b0}}, tol};
    flag.less = query < knot;
  end
endmodule
`default_nettype wire

/* hdl/nurbs_knot_vector_engine.sv */
// init, write and rejected requests complete in the idle state; insert shifts the cells once per inserted knot
// find span checks both ends of the range, then runs a binary search on the cell flags
// multiplicity examines one cell of the chain per cycle
// one request at a time, start taken while busy is low; done pulses one cycle
// synchronous reset clears the knot cells, last index and both registers to zero
`default_nettype none
module nurbs_knot_vector_engine (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  output logic                           busy,
  output logic                           done,
  input  wire logic [2:0]                action,
  input  wire logic [nkv_pkg::IdxW-1:0]  last_index,
  input  wire logic [nkv_pkg::IdxW-1:0]  knot_index,
  input  wire logic signed [31:0]        knot_value,
  input  wire logic signed [31:0]        query_value,
  input  wire logic [nkv_pkg::IdxW-1:0]  insert_count,
  output logic [nkv_pkg::IdxW-1:0]       span_index,
  output logic [nkv_pkg::CntW-1:0]       multiplicity,
  output logic [nkv_pkg::IdxW-1:0]       current_last,
  output logic                           status,
  input  wire logic                      cfg_we,
  input  wire logic                      cfg_index,
  input  wire logic [nkv_pkg::TolW-1:0]  cfg_data
);
  import nkv_pkg::*;
  `include "nurbs_knot_vector_engine_defines.svh"

  typedef enum logic [2:0] {
    S_IDLE, S_SHIFT, S_SPAN0, S_SEARCH, S_FIND, S_DOWN, S_UP
  } state_t;

  state_t st;
  logic [3:0] degree;
  logic [TolW-1:0] tol;
  logic [IdxW-1:0] last;
  logic [IdxW-1:0] idx;
  logic [IdxW-1:0] cnt;
  logic [IdxW-1:0] ins_total;
  knot_t kval, q, ref_value;
  logic [CntW-1:0] low, high, ptr, mult;
  logic init_go, write_go;

  knot_t knots [NumKnots];
  cell_flag_t flags [NumKnots];
  logic [NumKnots-1:0] near_v, less_v;

  logic [CntW-1:0] mid;
  logic [CntW-1:0] top;

  assign mid = CntW'((low + high) >> 1);
  assign top = CntW'(last) - CntW'(degree) - CntW'(1);
  assign busy = st != S_IDLE;

  // init and write land in the cells at the accepting edge
  assign init_go = start && st == S_IDLE && action == ActInit;
  assign write_go = start && st == S_IDLE && action == ActWrite && knot_index <= last;

  for (genvar i = 0; i < NumKnots; i++) begin : g_cell
    cell_ctl_t ctl;
    knot_t din;
    always_comb begin
      ctl.load = (init_go && i <= int'(last_index))
              || (write_go && i == int'(knot_index))
              || (st == S_SHIFT && i == int'(idx) + 1);
      ctl.shift = st == S_SHIFT && i >= int'(idx) + 2;
      if (init_go) begin
        din = (i <= int'(last_index >> 1)) ? '0 : knot_t'(OneQ16);
      end else if (write_go) begin
        din = knot_value;
      end else begin
        din = kval;
      end
    end
    nkv_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .din       (din),
      .left      ((i == 0) ? knot_t'(0) : knots[(i == 0) ? 0 : i-1]),
      .ref_value (ref_value),
      .query     (q),
      .tol       (tol),
      .knot      (knots[i]),
      .flag      (flags[i])
    );
    assign near_v[i] = flags[i].near;
    assign less_v[i] = flags[i].less;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      degree <= '0;
      tol <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CfgDegree:    degree <= cfg_data[3:0];
        CfgTolerance: tol <= cfg_data;
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
      done <= 1'b0;
      last <= '0;
      span_index <= '0;
      multiplicity <= '0;
      current_last <= '0;
      status <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (st)
        S_IDLE: begin
          if (start) begin
            idx <= knot_index;
            kval <= knot_value;
            q <= query_value;
            cnt <= insert_count;
            ins_total <= insert_count;
            span_index <= '0;
            multiplicity <= '0;
            status <= 1'b0;
            mult <= CntW'(1);
            unique case (action)
              ActInit: begin
                last <= last_index;
                current_last <= last_index;
                done <= 1'b1;
              end
              ActWrite: begin
                status <= knot_index > last;
                current_last <= last;
                done <= 1'b1;
              end
              ActSpan: begin
                if (CntW'(last) < {2'b0, degree, 1'b1}) begin
                  span_index <= IdxW'(degree);
                  current_last <= last;
                  done <= 1'b1;
                end else begin
                  st <= S_SPAN0;
                end
              end
              ActInsert: begin
                if (knot_index > last
                    || CntW'(last) + CntW'(insert_count) > CntW'(LastLimit)) begin
                  status <= 1'b1;
                  current_last <= last;
                  done <= 1'b1;
                end else if (insert_count == '0) begin
                  current_last <= last;
                  done <= 1'b1;
                end else begin
                  st <= S_SHIFT;
                end
              end
              ActMultIdx: begin
                if (knot_index > last) begin
                  status <= 1'b1;
                  current_last <= last;
                  done <= 1'b1;
                end else begin
                  ref_value <= knots[knot_index];
                  ptr <= CntW'(knot_index);
                  st <= S_DOWN;
                end
              end
              ActMultVal: begin
                ref_value <= query_value;
                ptr <= '0;
                st <= S_FIND;
              end
              default: begin
                status <= 1'b1;
                current_last <= last;
                done <= 1'b1;
              end
            endcase
          end
        end
        S_SHIFT: begin
          cnt <= cnt - IdxW'(1);
          if (cnt == IdxW'(1)) begin
            last <= last + ins_total;
            current_last <= last + ins_total;
            done <= 1'b1;
            st <= S_IDLE;
          end
        end
        S_SPAN0: begin
          if (!less_v[top[IdxW-1:0] + IdxW'(1)]) begin
            span_index <= top[IdxW-1:0];
            current_last <= last;
            done <= 1'b1;
            st <= S_IDLE;
          end else if (less_v[{2'b0, degree}]) begin
            span_index <= IdxW'(degree);
            current_last <= last;
            done <= 1'b1;
            st <= S_IDLE;
          end else begin
            low <= CntW'(degree);
            high <= top + CntW'(1);
            st <= S_SEARCH;
          end
        end
        S_SEARCH: begin
          if (high - low > CntW'(1)) begin
            if (less_v[mid[IdxW-1:0]]) begin
              high <= mid;
            end else begin
              low <= mid;
            end
          end else begin
            span_index <= low[IdxW-1:0];
            current_last <= last;
            done <= 1'b1;
            st <= S_IDLE;
          end
        end
        S_FIND: begin
          if (ptr > CntW'(last)) begin
            current_last <= last;
            done <= 1'b1;
            st <= S_IDLE;
          end else if (near_v[ptr[IdxW-1:0]]) begin
            idx <= ptr[IdxW-1:0];
            ref_value <= knots[ptr[IdxW-1:0]];
            st <= S_DOWN;
          end else begin
            ptr <= ptr + CntW'(1);
          end
        end
        S_DOWN: begin
          if (ptr != '0 && near_v[ptr[IdxW-1:0] - IdxW'(1)]) begin
            mult <= mult + CntW'(1);
            ptr <= ptr - CntW'(1);
          end else begin
            ptr <= CntW'(idx) + CntW'(1);
            st <= S_UP;
          end
        end
        S_UP: begin
          if (ptr <= CntW'(last) && near_v[ptr[IdxW-1:0]]) begin
            mult <= mult + CntW'(1);
            ptr <= ptr + CntW'(1);
          end else begin
            multiplicity <= mult;
            current_last <= last;
            done <= 1'b1;
            st <= S_IDLE;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  `NKV_ASSERT_IMP(a_done_idle, done, !busy)
  `NKV_ASSERT_IMP(a_search_order, st == S_SEARCH, low < high)
  `NKV_ASSERT_IMP(a_reject_clean, done && status, span_index == '0 && multiplicity == '0)
  `NKV_ASSERT_NXT(a_shift_count, st == S_SHIFT && cnt != IdxW'(1), st == S_SHIFT)
endmodule
`default_nettype wire

/* test/tb_nurbs_knot_vector_engine.sv */
`default_nettype none
module tb_nurbs_knot_vector_engine;
  timeunit 1ns;
  timeprecision 1ps;
  import nkv_pkg::*;

  typedef struct {
    logic [2:0] act;
    logic [IdxW-1:0] last;
    logic [IdxW-1:0] idx;
    logic signed [31:0] kv;
    logic signed [31:0] qv;
    logic [IdxW-1:0] cnt;
  } knot_req_t;

  typedef struct {
    logic [IdxW-1:0] span;
    logic [CntW-1:0] mult;
    logic [IdxW-1:0] cur;
    logic st;
  } knot_rsp_t;

  typedef struct {
    knot_req_t r;
    bit fixed;
    knot_rsp_t e;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy, done;
  logic [2:0] action = '0;
  logic [IdxW-1:0] last_index = '0, knot_index = '0, insert_count = '0;
  logic signed [31:0] knot_value = '0, query_value = '0;
  logic [IdxW-1:0] span_index, current_last;
  logic [CntW-1:0] multiplicity;
  logic status;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [TolW-1:0] cfg_data = '0;

  nurbs_knot_vector_engine dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
    .action(action), .last_index(last_index), .knot_index(knot_index),
    .knot_value(knot_value), .query_value(query_value), .insert_count(insert_count),
    .span_index(span_index), .multiplicity(multiplicity), .current_last(current_last),
    .status(status), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("simulation failed");
    $finish;
  end

  // shadow state of the knot table
  logic signed [KnotW-1:0] knots [NumKnots];
  int unsigned m_last;
  int unsigned deg;
  int unsigned tol;

  knot_rsp_t pending_q [$];
  int errors = 0;
  int sent = 0;
  bit no_gap = 0;

  function automatic bit knots_close(longint a, longint b);
    longint d;
    d = (a >= b) ? a - b : b - a;
    return d <= longint'(tol);
  endfunction

  function automatic int unsigned run_length(int unsigned at);
    int unsigned c;
    int i;
    c = 1;
    for (i = int'(at) - 1; i >= 0 && knots_close(knots[at], knots[i]); i--) c++;
    for (i = at + 1; i <= int'(m_last) && knots_close(knots[at], knots[i]); i++) c++;
    return c;
  endfunction

  function automatic int unsigned locate_span(logic signed [31:0] u);
    int unsigned top, lo, hi, mid;
    if (m_last < 2 * deg + 1) return deg;
    top = m_last - deg - 1;
    if (u >= knots[top + 1]) return top;
    if (u < knots[deg]) return deg;
    lo = deg;
    hi = top + 1;
    while (hi - lo > 1) begin
      mid = (lo + hi) / 2;
      if (u < knots[mid]) hi = mid;
      else lo = mid;
    end
    return lo;
  endfunction

  function automatic knot_rsp_t apply_request(knot_req_t r);
    knot_rsp_t o;
    int i;
    o = '{default: '0};
    case (r.act)
      ActInit: begin
        m_last = r.last;
        for (i = 0; i <= int'(r.last); i++)
          knots[i] = (i <= int'(r.last) / 2) ? '0 : OneQ16;
      end
      ActWrite: begin
        if (r.idx > m_last) o.st = 1'b1;
        else knots[r.idx] = r.kv;
      end
      ActSpan: o.span = IdxW'(locate_span(r.qv));
      ActInsert: begin
        if (r.idx > m_last || m_last + r.cnt > LastLimit) o.st = 1'b1;
        else begin
          for (i = m_last; i > int'(r.idx); i--) knots[i + r.cnt] = knots[i];
          for (i = 1; i <= int'(r.cnt); i++) knots[r.idx + i] = r.kv;
          m_last = m_last + r.cnt;
        end
      end
      ActMultIdx: begin
        if (r.idx > m_last) o.st = 1'b1;
        else o.mult = CntW'(run_length(r.idx));
      end
      ActMultVal: begin
        for (i = 0; i <= int'(m_last); i++)
          if (knots_close(r.qv, knots[i])) begin
            o.mult = CntW'(run_length(i));
            break;
          end
      end
      default: o.st = 1'b1;
    endcase
    o.cur = IdxW'(m_last);
    return o;
  endfunction

  always @(posedge clk) begin : result_check
    knot_rsp_t e;
    if (!rst && done) begin
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result at %0t", $realtime);
      end else begin
        e = pending_q.pop_front();
        if (span_index !== e.span || multiplicity !== e.mult ||
            current_last !== e.cur || status !== e.st) begin
          errors++;
          if (errors <= 10)
            $display("mismatch at %0t: exp span %0d mult %0d last %0d st %0d, got %0d %0d %0d %0d",
                     $realtime, e.span, e.mult, e.cur, e.st,
                     span_index, multiplicity, current_last, status);
        end
      end
    end
  end

  task automatic issue(knot_req_t r, bit fixed = 0, knot_rsp_t e = '{default: '0});
    int gap;
    knot_rsp_t p;
    gap = no_gap ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    action = r.act;
    last_index = r.last;
    knot_index = r.idx;
    knot_value = r.kv;
    query_value = r.qv;
    insert_count = r.cnt;
    start = 1'b1;
    do @(posedge clk); while (busy);
    p = apply_request(r);
    pending_q.push_back(fixed ? e : p);
    sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    start = 1'b0;
    while (pending_q.size() != 0) @(negedge clk);
  endtask

  task automatic set_reg(logic which, int unsigned val);
    cfg_we = 1'b1;
    cfg_index = which;
    cfg_data = TolW'(val);
    @(negedge clk);
    cfg_we = 1'b0;
    if (which == CfgDegree) deg = val & 15;
    else tol = val & 16'hffff;
  endtask

  function automatic knot_req_t mk(int a, int l, int ix, logic [31:0] kv,
                                   logic [31:0] qv, int c);
    knot_req_t r;
    r.act = 3'(a);
    r.last = IdxW'(l);
    r.idx = IdxW'(ix);
    r.kv = kv;
    r.qv = qv;
    r.cnt = IdxW'(c);
    return r;
  endfunction

  function automatic knot_rsp_t rs(int s, int mu, int cl, int st);
    knot_rsp_t o;
    o.span = IdxW'(s);
    o.mult = CntW'(mu);
    o.cur = IdxW'(cl);
    o.st = st[0];
    return o;
  endfunction

  function automatic logic [31:0] near_value(int unsigned step, int unsigned hi);
    logic [31:0] v;
    v = $urandom_range(0, hi) * step;
    case ($urandom_range(0, 5))
      0: v = v + $urandom_range(0, 2 * tol + 2) - tol - 1;
      1: v = $urandom;
      default: ;
    endcase
    return v;
  endfunction

  task automatic shaped_episode();
    int unsigned m, step, rep, n, k, sel;
    m = $urandom_range(0, 3) == 0 ? $urandom_range(0, 63) : $urandom_range(0, 40);
    step = $urandom_range(1, 4) * 32'h1000;
    rep = $urandom_range(1, 3);
    issue(mk(ActInit, m, 0, 0, 0, 1));
    for (k = 0; k <= m; k++)
      if ($urandom_range(0, 7) != 0)
        issue(mk(ActWrite, 0, k, (k / rep) * step - 32'h8000, 0, 1));
    n = $urandom_range(4, 12);
    repeat (n) begin
      sel = $urandom_range(0, 9);
      if (sel < 4)
        issue(mk(ActSpan, 0, 0, 0, near_value(step, m / rep + 1) - 32'h8000, 1));
      else if (sel < 6)
        issue(mk(ActMultIdx, 0, $urandom_range(0, m_last + 1), 0, 0, 1));
      else if (sel < 8)
        issue(mk(ActMultVal, 0, 0, 0, near_value(step, m / rep + 1) - 32'h8000, 1));
      else
        issue(mk(ActInsert, 0, $urandom_range(0, m_last), near_value(step, m / rep) - 32'h8000,
                 0, $urandom_range(1, 4)));
    end
  endtask

  task automatic noise_item();
    issue(mk($urandom_range(0, 7), $urandom_range(0, 63), $urandom_range(0, 63),
             $urandom, $urandom_range(0, 1) ? $urandom : near_value(32'h4000, 8),
             $urandom_range(0, 63)));
  endtask

  initial begin : stimulus
    dir_row_t tab [$];
    int unsigned degs [5] = '{15, 3, 0, 1, 7};
    int unsigned tols [5] = '{65535, 256, 0, 1, 4096};
    int ph, base;
    for (int i = 0; i < NumKnots; i++) knots[i] = '0;
    m_last = 0;
    deg = 0;
    tol = 0;
    tab.push_back('{mk(ActSpan, 0, 0, 0, 0, 1), 1, rs(0, 0, 0, 0)});
    tab.push_back('{mk(6, 63, 63, '1, '1, 63), 1, rs(0, 0, 0, 1)});
    tab.push_back('{mk(7, 0, 0, 0, 0, 0), 1, rs(0, 0, 0, 1)});
    tab.push_back('{mk(ActWrite, 0, 5, 32'h1234, 0, 1), 1, rs(0, 0, 0, 1)});
    tab.push_back('{mk(ActInit, 63, 0, 0, 0, 1), 1, rs(0, 0, 63, 0)});
    tab.push_back('{mk(ActMultIdx, 0, 0, 0, 0, 1), 1, rs(0, 32, 63, 0)});
    tab.push_back('{mk(ActMultVal, 0, 0, 0, OneQ16, 1), 1, rs(0, 32, 63, 0)});
    tab.push_back('{mk(ActMultVal, 0, 0, 0, 32'h7fffffff, 1), 1, rs(0, 0, 63, 0)});
    tab.push_back('{mk(ActInsert, 0, 3, 0, 0, 1), 1, rs(0, 0, 63, 1)});
    tab.push_back('{mk(ActInit, 7, 0, 0, 0, 1), 1, rs(0, 0, 7, 0)});
    tab.push_back('{mk(ActWrite, 0, 7, 32'h7fffffff, 0, 1), 0, rs(0, 0, 0, 0)});
    tab.push_back('{mk(ActWrite, 0, 0, 32'h80000000, 0, 1), 0, rs(0, 0, 0, 0)});
    tab.push_back('{mk(ActSpan, 0, 0, 0, 32'h80000000, 1), 0, rs(0, 0, 0, 0)});
    tab.push_back('{mk(ActSpan, 0, 0, 0, 32'h7fffffff, 1), 0, rs(0, 0, 0, 0)});
    tab.push_back('{mk(ActSpan, 0, 0, 0, 32'h8000, 1), 0, rs(0, 0, 0, 0)});
    tab.push_back('{mk(ActInsert, 0, 2, 0, 0, 63), 1, rs(0, 0, 7, 1)});
    tab.push_back('{mk(ActInsert, 0, 2, 32'h8000, 0, 3), 0, rs(0, 0, 0, 0)});
    tab.push_back('{mk(ActInsert, 0, 40, 32'h8000, 0, 1), 1, rs(0, 0, 10, 1)});
    tab.push_back('{mk(ActMultIdx, 0, 40, 0, 0, 1), 1, rs(0, 0, 10, 1)});
    tab.push_back('{mk(ActMultIdx, 0, 4, 0, 0, 1), 0, rs(0, 0, 0, 0)});
    tab.push_back('{mk(ActMultVal, 0, 0, 0, 32'h8000, 1), 0, rs(0, 0, 0, 0)});
    tab.push_back('{mk(ActInsert, 0, 1, 32'h4000, 0, 0), 0, rs(0, 0, 0, 0)});
    tab.push_back('{mk(ActWrite, 0, 1, 32'h5555aaaa, 0, 1), 0, rs(0, 0, 0, 0)});
    tab.push_back('{mk(ActSpan, 0, 0, 0, 32'h5555aaaa, 1), 0, rs(0, 0, 0, 0)});
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    foreach (tab[i]) issue(tab[i].r, tab[i].fixed, tab[i].e);
    drain();
    for (ph = 0; ph < 5; ph++) begin
      set_reg(CfgDegree, degs[ph]);
      set_reg(CfgTolerance, tols[ph]);
      no_gap = (ph == 2);
      base = sent;
      while (sent < base + 240) begin
        if ($urandom_range(0, 4) != 0) begin
          shaped_episode();
        end else begin
          repeat (5) noise_item();
        end
        if ($urandom_range(0, 15) == 0) drain();
      end
      drain();
    end
    repeat (150) @(posedge clk);
    if (errors == 0 && pending_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
`default_nettype wire

/* filelist.f */
+incdir+hdl
hdl/nkv_pkg.sv
hdl/nkv_cell.sv
hdl/nurbs_knot_vector_engine.sv
test/tb_nurbs_knot_vector_engine.sv
